[sv/asp_pkg.sv]
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, widths and constants for the Archimedean spiral point core.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int IDX_W    = 10;   // point index
  localparam int TURN_W   = 7;    // turn count register
  localparam int PCNT_W   = 11;   // point count register
  localparam int PHASE_W  = TURN_W + IDX_W;      // turn_count * index
  localparam int FRAC_W   = 32;                  // fraction of a turn, Q32
  localparam int RATIO_W  = PHASE_W + FRAC_W;    // angle in turns, integer + Q32
  localparam int TRIG_W   = 33;                  // CORDIC datapath, signed Q30
  localparam int RAD_W    = 38;                  // radius, Q16
  localparam int COORD_W  = 19;                  // output coordinate, Q8
  localparam int TABLE_LEN = 24;                 // arctangent table length

  localparam int RK_LO_W  = 52;                  // ratio[31:0] * 3pi
  localparam int RK_HI_W  = 37;                  // ratio[48:32] * 3pi
  localparam int ZP_W     = 61;                  // residual * pi/2

  localparam logic [19:0] THREE_PI_Q16 = 20'd617662;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [16:0] RAD_BASE     = 17'd98304;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032874;

  localparam logic signed [33:0] COORD_MAX = 34'sd262143;
  localparam logic signed [33:0] COORD_MIN = -34'sd262144;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TURN_COUNT  = 1'b0,
    REG_POINT_COUNT = 1'b1
  } cfg_reg_t;

  // item handed from the front end to the back end
  typedef struct packed {
    logic               ok;      // index in range
    logic [PHASE_W-1:0] phase;   // turn_count * index
  } asp_item_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } asp_q_stat_t;

  // arctangent of 2^-i in Q30
  function automatic logic signed [TRIG_W-1:0] atan_q30(input int unsigned i);
    logic signed [TRIG_W-1:0] v;
    case (i)
      0:  v = 33'sd843314857;
      1:  v = 33'sd497837829;
      2:  v = 33'sd263043837;
      3:  v = 33'sd133525159;
      4:  v = 33'sd67021687;
      5:  v = 33'sd33543516;
      6:  v = 33'sd16775851;
      7:  v = 33'sd8388437;
      8:  v = 33'sd4194283;
      9:  v = 33'sd2097149;
      10: v = 33'sd1048576;
      11: v = 33'sd524288;
      12: v = 33'sd262144;
      13: v = 33'sd131072;
      14: v = 33'sd65536;
      15: v = 33'sd32768;
      16: v = 33'sd16384;
      17: v = 33'sd8192;
      18: v = 33'sd4096;
      19: v = 33'sd2048;
      20: v = 33'sd1024;
      21: v = 33'sd512;
      22: v = 33'sd256;
      23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/asp_front.sv]
// ----------------------------------------------------------------------------
// asp_front
// Accepts a point index, checks its range and forms the integer phase.
// ----------------------------------------------------------------------------
module asp_front #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [asp_pkg::IDX_W-1:0]   point_index,
  input  logic [asp_pkg::TURN_W-1:0]  turn_count,
  input  logic [asp_pkg::PCNT_W-1:0]  point_count,
  output logic                        item_vld,
  output asp_pkg::asp_item_t          item
);
  import asp_pkg::*;

  logic      vld_r, vld_nxt;
  asp_item_t item_r, item_nxt;

  // classify and form phase
  always_comb begin
    vld_nxt        = accept;
    item_nxt.ok    = ({1'b0, point_index} < point_count) &&
                     (32'(point_index) < 32'(MAX_POINTS));
    item_nxt.phase = PHASE_W'(turn_count) * PHASE_W'(point_index);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

[sv/asp_queue.sv]
// ----------------------------------------------------------------------------
// asp_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module asp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  asp_pkg::asp_item_t   push_item,
  input  logic                 pop,
  output asp_pkg::asp_item_t   pop_item,
  output asp_pkg::asp_q_stat_t stat
);
  import asp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  asp_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

endmodule

[sv/asp_div.sv]
// ----------------------------------------------------------------------------
// asp_div
// Pipelined restoring divider: (phase * 2^32) / point_count, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module asp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  asp_pkg::asp_item_t           in_item,
  input  logic [asp_pkg::PCNT_W-1:0]   divisor,
  output logic                         out_vld,
  output logic                         out_ok,
  output logic [asp_pkg::RATIO_W-1:0]  out_ratio
);
  import asp_pkg::*;

  localparam int NST = RATIO_W;

  // per stage: numerator bits shift out at the top, quotient bits in at the bottom
  logic               vld_r [NST];
  logic               ok_r  [NST];
  logic [PCNT_W-1:0]  rem_r [NST];
  logic [RATIO_W-1:0] nq_r  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic               vld_in, ok_in;
    logic [PCNT_W-1:0]  rem_in, rem_nxt;
    logic [RATIO_W-1:0] nq_in, nq_nxt;
    logic [PCNT_W:0]    trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign ok_in  = in_item.ok;
      assign rem_in = '0;
      assign nq_in  = {in_item.phase, FRAC_W'(0)};
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign ok_in  = ok_r[k-1];
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
    end

    // trial subtract
    always_comb begin
      trial   = {rem_in, nq_in[RATIO_W-1]};
      ge      = (trial >= {1'b0, divisor});
      rem_nxt = ge ? PCNT_W'(trial - {1'b0, divisor}) : PCNT_W'(trial);
      nq_nxt  = {nq_in[RATIO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      ok_r[k]  <= ok_in;
      rem_r[k] <= rem_nxt;
      nq_r[k]  <= nq_nxt;
    end
  end

  assign out_vld   = vld_r[NST-1];
  assign out_ok    = ok_r[NST-1];
  assign out_ratio = nq_r[NST-1];

endmodule

[sv/asp_back.sv]
// ----------------------------------------------------------------------------
// asp_back
// Radius and start angle, pipelined CORDIC rotation, quadrant fold, scaling
// by the radius with rounding and saturation.
// ----------------------------------------------------------------------------
module asp_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic                                in_ok,
  input  logic [asp_pkg::RATIO_W-1:0]         in_ratio,
  output logic                                out_vld,
  output logic signed [asp_pkg::COORD_W-1:0]  out_x,
  output logic signed [asp_pkg::COORD_W-1:0]  out_y,
  output logic                                out_ok
);
  import asp_pkg::*;

  localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int RL_W = 19;
  localparam int RH_W = RAD_W - RL_W;
  localparam int PP_W = RL_W + 1 + TRIG_W;
  localparam int SUM_W = 72;

  // stage A: products for radius and start angle
  logic               a_vld_r, a_ok_r;
  logic [1:0]         a_quad_r;
  logic [RK_LO_W-1:0] a_rklo_r;
  logic [RK_HI_W-1:0] a_rkhi_r;
  logic [ZP_W-1:0]    a_zp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ok_r   <= in_ok;
    a_quad_r <= in_ratio[31:30];
    a_rklo_r <= RK_LO_W'(in_ratio[FRAC_W-1:0]) * RK_LO_W'(THREE_PI_Q16);
    a_rkhi_r <= RK_HI_W'(in_ratio[RATIO_W-1:FRAC_W]) * RK_HI_W'(THREE_PI_Q16);
    a_zp_r   <= ZP_W'(in_ratio[29:0]) * ZP_W'(HALF_PI_Q30);
  end

  // stage B: radius sum and CORDIC start angle
  logic                     b_vld_r, b_ok_r;
  logic [1:0]               b_quad_r;
  logic [RAD_W-1:0]         b_rad_r;
  logic signed [TRIG_W-1:0] b_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_ok_r   <= a_ok_r;
    b_quad_r <= a_quad_r;
    b_rad_r  <= RAD_W'(RAD_BASE) + RAD_W'(a_rkhi_r) + RAD_W'(a_rklo_r[RK_LO_W-1:32]);
    b_z_r    <= $signed({2'b00, a_zp_r[ZP_W-1:30]});
  end

  // CORDIC rotation stages
  logic                     c_vld_r  [NS];
  logic                     c_ok_r   [NS];
  logic [1:0]               c_quad_r [NS];
  logic [RAD_W-1:0]         c_rad_r  [NS];
  logic signed [TRIG_W-1:0] c_x_r    [NS];
  logic signed [TRIG_W-1:0] c_y_r    [NS];
  logic signed [TRIG_W-1:0] c_z_r    [NS];

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic                     vld_in, ok_in;
    logic [1:0]               quad_in;
    logic [RAD_W-1:0]         rad_in;
    logic signed [TRIG_W-1:0] x_in, y_in, z_in;
    logic signed [TRIG_W-1:0] dx, dy, x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = b_vld_r;
      assign ok_in   = b_ok_r;
      assign quad_in = b_quad_r;
      assign rad_in  = b_rad_r;
      assign x_in    = CORDIC_X0;
      assign y_in    = '0;
      assign z_in    = b_z_r;
    end else begin : g_next
      assign vld_in  = c_vld_r[i-1];
      assign ok_in   = c_ok_r[i-1];
      assign quad_in = c_quad_r[i-1];
      assign rad_in  = c_rad_r[i-1];
      assign x_in    = c_x_r[i-1];
      assign y_in    = c_y_r[i-1];
      assign z_in    = c_z_r[i-1];
    end

    // one micro-rotation
    always_comb begin
      dx = y_in >>> i;
      dy = x_in >>> i;
      if (!z_in[TRIG_W-1]) begin
        x_nxt = x_in - dx;
        y_nxt = y_in + dy;
        z_nxt = z_in - atan_q30(i);
      end else begin
        x_nxt = x_in + dx;
        y_nxt = y_in - dy;
        z_nxt = z_in + atan_q30(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_vld_r[i] <= 1'b0;
      end else begin
        c_vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      c_ok_r[i]   <= ok_in;
      c_quad_r[i] <= quad_in;
      c_rad_r[i]  <= rad_in;
      c_x_r[i]    <= x_nxt;
      c_y_r[i]    <= y_nxt;
      c_z_r[i]    <= z_nxt;
    end
  end

  // stage M: quadrant fold and partial products against the radius halves
  logic                     m_vld_r, m_ok_r;
  logic signed [PP_W-1:0]   m_xh_r, m_xl_r, m_yh_r, m_yl_r;
  logic signed [TRIG_W-1:0] cs, sn, cx, cy;
  logic signed [RL_W:0]     rl_s;
  logic signed [RH_W:0]     rh_s;

  assign cx   = c_x_r[NS-1];
  assign cy   = c_y_r[NS-1];
  assign rl_s = $signed({1'b0, c_rad_r[NS-1][RL_W-1:0]});
  assign rh_s = $signed({1'b0, c_rad_r[NS-1][RAD_W-1:RL_W]});

  always_comb begin
    case (c_quad_r[NS-1])
      2'd0: begin
        cs = cx;
        sn = cy;
      end
      2'd1: begin
        cs = -cy;
        sn = cx;
      end
      2'd2: begin
        cs = -cx;
        sn = -cy;
      end
      default: begin
        cs = cy;
        sn = -cx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    m_ok_r <= c_ok_r[NS-1];
    m_xh_r <= PP_W'(rh_s * cs);
    m_xl_r <= PP_W'(rl_s * cs);
    m_yh_r <= PP_W'(rh_s * sn);
    m_yl_r <= PP_W'(rl_s * sn);
  end

  // stage F: combine, round to Q8 and saturate
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [33:0]      q_x, q_y;
  logic signed [COORD_W-1:0] sat_x, sat_y;
  logic                      f_vld_r, f_ok_r;
  logic signed [COORD_W-1:0] f_x_r, f_y_r;

  always_comb begin
    sum_x = ({{(SUM_W-PP_W){m_xh_r[PP_W-1]}}, m_xh_r} <<< RL_W) +
            {{(SUM_W-PP_W){m_xl_r[PP_W-1]}}, m_xl_r} + (SUM_W'(1) <<< 37);
    sum_y = ({{(SUM_W-PP_W){m_yh_r[PP_W-1]}}, m_yh_r} <<< RL_W) +
            {{(SUM_W-PP_W){m_yl_r[PP_W-1]}}, m_yl_r} + (SUM_W'(1) <<< 37);
    q_x   = sum_x[SUM_W-1:38];
    q_y   = sum_y[SUM_W-1:38];
    if (q_x > COORD_MAX) begin
      sat_x = COORD_MAX[COORD_W-1:0];
    end else if (q_x < COORD_MIN) begin
      sat_x = COORD_MIN[COORD_W-1:0];
    end else begin
      sat_x = q_x[COORD_W-1:0];
    end
    if (q_y > COORD_MAX) begin
      sat_y = COORD_MAX[COORD_W-1:0];
    end else if (q_y < COORD_MIN) begin
      sat_y = COORD_MIN[COORD_W-1:0];
    end else begin
      sat_y = q_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= m_vld_r;
    end
  end

  // out-of-range index gives zeros
  always_ff @(posedge clk) begin
    f_ok_r <= m_ok_r;
    f_x_r  <= m_ok_r ? sat_x : '0;
    f_y_r  <= m_ok_r ? sat_y : '0;
  end

  assign out_vld = f_vld_r;
  assign out_ok  = f_ok_r;
  assign out_x   = f_x_r;
  assign out_y   = f_y_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_ok |-> (out_x == '0) && (out_y == '0))
    else $error("out-of-range point with nonzero coordinates");

endmodule

[sv/archimedean_spiral_point_core.sv]
// ----------------------------------------------------------------------------
// archimedean_spiral_point_core
// Archimedean spiral point generator: index in, Cartesian point out (Q8).
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start / busy           in_point_index
//  result    out_valid (strobe)     out_coord_x, out_coord_y, out_index_valid
//  config    cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
//  One point per cycle while busy is low; after the edge that accepts
//  its start, a result passes the front register, queue, 49 divider
//  stages, radius and angle stages, CORDIC stages, fold and scale stages.
//  The divider pipeline, one quotient bit per stage, sets the latency.
//  Synchronous active-low reset clears all valid flags; config resets
//  to turn_count 5, point_count 21. No results are held off: the back
//  end always advances.
// ----------------------------------------------------------------------------
module archimedean_spiral_point_core #(
  parameter int MAX_POINTS    = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [asp_pkg::IDX_W-1:0]           in_point_index,
  output logic                                out_valid,
  output logic signed [asp_pkg::COORD_W-1:0]  out_coord_x,
  output logic signed [asp_pkg::COORD_W-1:0]  out_coord_y,
  output logic                                out_index_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [asp_pkg::PCNT_W-1:0]          cfg_wdata
);
  import asp_pkg::*;

  logic [TURN_W-1:0] turn_count_r, turn_count_nxt;
  logic [PCNT_W-1:0] point_count_r, point_count_nxt;
  logic              cfg_xfer;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_comb begin
    turn_count_nxt  = turn_count_r;
    point_count_nxt = point_count_r;
    if (cfg_xfer) begin
      case (cfg_reg_t'(cfg_index))
        REG_TURN_COUNT:  turn_count_nxt  = cfg_wdata[TURN_W-1:0];
        REG_POINT_COUNT: point_count_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_count_r  <= TURN_W'(5);
      point_count_r <= PCNT_W'(21);
    end else begin
      turn_count_r  <= turn_count_nxt;
      point_count_r <= point_count_nxt;
    end
  end

  // front end
  logic        accept;
  logic        fr_vld;
  asp_item_t   fr_item;
  asp_item_t   q_item;
  asp_q_stat_t q_stat;

  assign accept = start && !busy;
  assign busy   = q_stat.full;

  asp_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .point_index(in_point_index),
    .turn_count (turn_count_r),
    .point_count(point_count_r),
    .item_vld   (fr_vld),
    .item       (fr_item)
  );

  // decoupling queue; back end drains it every cycle
  asp_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_vld),
    .push_item(fr_item),
    .pop      (!q_stat.empty),
    .pop_item (q_item),
    .stat     (q_stat)
  );

  // back end: divider then trig and scaling
  logic               dv_vld, dv_ok;
  logic [RATIO_W-1:0] dv_ratio;

  asp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (!q_stat.empty),
    .in_item  (q_item),
    .divisor  (point_count_r),
    .out_vld  (dv_vld),
    .out_ok   (dv_ok),
    .out_ratio(dv_ratio)
  );

  asp_back #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dv_vld),
    .in_ok   (dv_ok),
    .in_ratio(dv_ratio),
    .out_vld (out_valid),
    .out_x   (out_coord_x),
    .out_y   (out_coord_y),
    .out_ok  (out_index_valid)
  );

endmodule
